>>> rtl/lgw_pkg.sv
// Package with widths, coefficient table and constants of the interpolation weight pipeline.
package lgw_pkg;
   localparam int NODE_COUNT = 7;
   localparam int WIDE_W     = 120;
   localparam int COEF_W     = 12;
   localparam int N_W        = 17;
   localparam int X_W        = 18;
   localparam int W_W        = 20;
   localparam int DEFAULT_MAX_ORDER = 6;
   localparam logic [N_W-1:0] X_LIMIT = 17'd66191;

   localparam logic [1:0] ORDER_2     = 2'd0;
   localparam logic [1:0] ORDER_4     = 2'd1;
   localparam logic [1:0] ORDER_6     = 2'd2;
   localparam logic [1:0] ORDER_SPARE = 2'd3;

   localparam logic signed [COEF_W-1:0] COEF [3][NODE_COUNT][NODE_COUNT] = '{
      '{ '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0},
         '{0,-360,360,0,0,0,0}, '{720,0,-720,0,0,0,0}, '{0,360,360,0,0,0,0},
         '{0,0,0,0,0,0,0}, '{0,0,0,0,0,0,0} },
      '{ '{0,0,0,0,0,0,0},
         '{0,60,-30,-60,30,0,0}, '{0,-480,480,120,-120,0,0},
         '{720,0,-900,0,180,0,0}, '{0,480,480,-120,-120,0,0},
         '{0,-60,-30,60,30,0,0}, '{0,0,0,0,0,0,0} },
      '{ '{0,-12,4,15,-5,-3,1}, '{0,108,-54,-120,60,12,-6},
         '{0,-540,540,195,-195,-15,15}, '{720,0,-980,0,280,0,-20},
         '{0,540,540,-195,-195,15,15}, '{0,-108,-54,120,60,-12,-6},
         '{0,12,4,-15,-5,3,1} }
   };

   function automatic logic signed [COEF_W-1:0] coef_of(input logic [1:0] order,
                                                         input int node, input int k);
      logic [1:0] sel;
      sel = (order == ORDER_SPARE) ? ORDER_6 : order;
      return COEF[sel][node][k];
   endfunction
endpackage

>>> rtl/lgw_horner_step.sv
// One Horner step h*n + c*2^(16*(6-k)), split into a partial product stage and a sum stage.
module lgw_horner_step
   import lgw_pkg::*;
#(
   parameter int K = 0
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [WIDE_W-1:0]  h_in,
   input  logic [N_W-1:0]            n_in,
   input  logic signed [COEF_W-1:0]  c_in,
   output logic signed [WIDE_W-1:0]  h_out,
   output logic [N_W-1:0]            n_out
);
   localparam int SHIFT = 16 * (6 - K);

   logic signed [48:0] pp0_ff, pp1_ff, pp2_ff, pp0_in, pp1_in, pp2_in;
   logic signed [47:0] pp3_ff, pp3_in;
   logic signed [COEF_W-1:0] c_ff;
   logic [N_W-1:0] n_ff, n2_ff;
   logic signed [WIDE_W-1:0] h_ff, h_in_sum;
   logic signed [N_W:0] ns;

   always_comb begin
      ns     = $signed({1'b0, n_in});
      pp0_in = $signed({1'b0, h_in[29:0]}) * ns;
      pp1_in = $signed({1'b0, h_in[59:30]}) * ns;
      pp2_in = $signed({1'b0, h_in[89:60]}) * ns;
      pp3_in = $signed(h_in[119:90]) * ns;
   end

   always_comb begin
      h_in_sum = WIDE_W'(pp0_ff) + (WIDE_W'(pp1_ff) <<< 30) + (WIDE_W'(pp2_ff) <<< 60)
               + (WIDE_W'(pp3_ff) <<< 90) + (WIDE_W'(c_ff) <<< SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp0_ff <= pp0_in;
         pp1_ff <= pp1_in;
         pp2_ff <= pp2_in;
         pp3_ff <= pp3_in;
         c_ff   <= c_in;
         n_ff   <= n_in;
         h_ff   <= h_in_sum;
         n2_ff  <= n_ff;
      end
   end

   assign h_out = h_ff;
   assign n_out = n2_ff;
endmodule

>>> rtl/lgw_round.sv
// Rounds the exact polynomial value to Q3.16 by a reciprocal multiply and saturates it.
module lgw_round
   import lgw_pkg::*;
(
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [WIDE_W-1:0] s_in,
   output logic signed [W_W-1:0]    w_out
);
   localparam logic [WIDE_W-1:0] HALF  = WIDE_W'(360) << 80;
   localparam logic [30:0]       RECIP = 31'd1527099484;
   localparam logic [24:0]       Q_SAT = 25'd524288;

   logic [WIDE_W-1:0] mag, rnd;
   logic [29:0] v_ff, v_in;
   logic neg_ff, neg2_ff;
   logic [60:0] prod_ff;
   logic [24:0] q;
   logic signed [W_W-1:0] w_ff, w_in;

   always_comb begin
      mag  = s_in[WIDE_W-1] ? WIDE_W'(-s_in) : WIDE_W'(s_in);
      rnd  = mag + HALF;
      v_in = (rnd[WIDE_W-1:114] != '0) ? '1 : rnd[113:84];
   end

   always_comb begin
      q = prod_ff[60:36];
      if (q > Q_SAT) q = Q_SAT;
      if (neg2_ff) w_in = W_W'(-$signed({1'b0, q}));
      else if (q == Q_SAT) w_in = {1'b0, {(W_W-1){1'b1}}};
      else w_in = W_W'(q);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff    <= v_in;
         neg_ff  <= s_in[WIDE_W-1];
         prod_ff <= 61'(v_ff) * 61'(RECIP);
         neg2_ff <= neg_ff;
         w_ff    <= w_in;
      end
   end

   assign w_out = w_ff;
endmodule

>>> rtl/lagrange_interp_weights_top.sv
// Top level of the Lagrange interpolation weight pipeline.
// Each input passes the input register, the Horner steps and the rounding registers to rsp.
// Throughput is one item per cycle unless stalled; six Horner steps of two stages each set the depth.
// The whole pipeline stalls while a result waits and rsp_tready is low.
// Synchronous reset clears all valid bits and sets the order code to order 4.
module lagrange_interp_weights_top
   import lgw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // offset_x[17:0], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // weight_m3, m2, m1, zero, p1, p2, p3 (20 each), zero pad
   output logic [0:0]   rsp_tuser,   // in_range
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data
);
   localparam int MAX_ORDER = DEFAULT_MAX_ORDER;
   localparam int NODES  = MAX_ORDER + 1;
   localparam int STAGES = 2 * MAX_ORDER + 4;

   logic [1:0] order_ff;
   logic [STAGES-1:0] valid_ff, ok_ff;
   logic advance, ok_in;
   logic [N_W-1:0] n0_ff;
   logic signed [W_W-1:0] w [NODES];

   assign advance    = !valid_ff[STAGES-1] || rsp_tready;
   assign req_tready = advance;
   assign csr_ready  = 1'b1;
   assign ok_in      = !req_tdata[X_W-1] && (req_tdata[N_W-1:0] <= X_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= ORDER_4;
         valid_ff <= '0;
      end else begin
         if (csr_valid) order_ff <= csr_data;
         if (advance) valid_ff <= {valid_ff[STAGES-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff <= {ok_ff[STAGES-2:0], ok_in};
         n0_ff <= req_tdata[N_W-1:0];
      end
   end

   genvar j, s;
   generate
      for (j = 0; j < NODES; j++) begin : g_node
         logic signed [WIDE_W-1:0] h [MAX_ORDER+1];
         logic [N_W-1:0] n [MAX_ORDER+1];
         assign h[0] = WIDE_W'(coef_of(order_ff, j, MAX_ORDER));
         assign n[0] = n0_ff;
         for (s = 0; s < MAX_ORDER; s++) begin : g_step
            lgw_horner_step #(.K(MAX_ORDER - 1 - s)) u_step (
               .clock (clock),
               .en    (advance),
               .h_in  (h[s]),
               .n_in  (n[s]),
               .c_in  (coef_of(order_ff, j, MAX_ORDER - 1 - s)),
               .h_out (h[s+1]),
               .n_out (n[s+1])
            );
         end
         lgw_round u_round (
            .clock (clock),
            .en    (advance),
            .s_in  (h[MAX_ORDER]),
            .w_out (w[j])
         );
         assign rsp_tdata[W_W*j +: W_W] = ok_ff[STAGES-1] ? w[j] : '0;
      end
   endgenerate

   assign rsp_tdata[143:W_W*NODES] = '0;
   assign rsp_tvalid = valid_ff[STAGES-1];
   assign rsp_tuser  = ok_ff[STAGES-1];
endmodule

>>> rtl/lgw_checker.sv
// Port-level checker for the interpolation weight pipeline and its bind statement.
module lgw_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic [0:0]   rsp_tuser
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("Out-of-range result carries nonzero weights.");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("Input stalled with an empty output stage.");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result transfer changed.");
endmodule

bind lagrange_interp_weights_top lgw_checker u_lgw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> dv/testbench.sv
// Testbench of the Lagrange interpolation weight pipeline with an exact integer predictor.
`timescale 1ns / 1ps

module testbench
   import lgw_pkg::*;
();

   typedef struct {
      logic signed [W_W-1:0] w [NODE_COUNT];
      logic                  in_range;
   } weights_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [23:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [143:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_data;

   logic [X_W-1:0] offset_queue [$];
   weights_type    weights_queue [$];
   logic [1:0]     order_shadow;
   int             tx_idle_pct;
   int             rx_idle_pct;
   int             rx_cycle;
   int             mismatches = 0;
   int             stall_cycles;

   lagrange_interp_weights_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [W_W-1:0] node_weight(logic [1:0] order, int node,
                                                         logic [N_W-1:0] n);
      logic signed [127:0] acc;
      logic signed [127:0] term;
      logic [127:0]        mag;
      logic [127:0]        q;
      logic [1:0]          sel;
      acc = 0;
      sel = (order == ORDER_SPARE) ? ORDER_6 : order;
      for (int k = 0; k < NODE_COUNT; k++) begin
         term = 128'(signed'(COEF[sel][node][k]));
         for (int i = 0; i < k; i++) term = term * $signed({111'd0, n});
         term = term <<< (16 * (6 - k));
         acc = acc + term;
      end
      mag = (acc < 0) ? 128'(-acc) : 128'(acc);
      q = ((mag + (128'd360 << 80)) >> 80) / 720;
      if (q > 128'd524288) q = 128'd524288;
      if (acc < 0) return -$signed(q[W_W:0]) < -524288 ? -20'sd524288 : W_W'(-q);
      if (q > 128'd524287) return 20'sd524287;
      return W_W'(q);
   endfunction

   function automatic weights_type interp_weights(logic [1:0] order, logic [X_W-1:0] x);
      weights_type r;
      r.in_range = !x[X_W-1] && (x[N_W-1:0] <= X_LIMIT);
      for (int j = 0; j < NODE_COUNT; j++)
         r.w[j] = r.in_range ? node_weight(order, j, x[N_W-1:0]) : '0;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            weights_queue.push_back(interp_weights(order_shadow, req_tdata[X_W-1:0]));
            void'(offset_queue.pop_front());
         end
         if (!req_tvalid || req_tready) begin
            if (offset_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= {6'd0, offset_queue[0]};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_cycle <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         rsp_tready <= !(rx_cycle >= 400 && rx_cycle < 700) &&
                       ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      weights_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (weights_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result transfer: %h", rsp_tdata);
         end else begin
            exp_w = weights_queue.pop_front();
            for (int j = 0; j < NODE_COUNT; j++) begin
               if (rsp_tdata[j*W_W +: W_W] !== exp_w.w[j]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Weight of node %0d: expected %0d, got %0d", j - 3,
                              exp_w.w[j], $signed(rsp_tdata[j*W_W +: W_W]));
               end
            end
            if (rsp_tuser[0] !== exp_w.in_range) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("In-range flag: expected %b, got %b", exp_w.in_range, rsp_tuser[0]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles > 5000) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (offset_queue.size() > 0 || weights_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_order(logic [1:0] order);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= order;
      do @(posedge clock); while (!csr_ready);
      order_shadow = order;
      csr_valid <= 1'b0;
   endtask

   task automatic push_random(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 80) offset_queue.push_back(X_W'($urandom_range(66191)));
         else if (pick < 90) offset_queue.push_back(X_W'($urandom()));
         else offset_queue.push_back(X_W'($urandom_range(66200, 66180)));
      end
   endtask

   initial begin
      logic [1:0] orders [6];
      logic [X_W-1:0] corners [10];
      orders = '{ORDER_4, ORDER_2, ORDER_6, ORDER_SPARE, ORDER_4, ORDER_6};
      corners = '{18'd0, 18'd1, 18'd32768, 18'd65535, 18'd65536, 18'd66191, 18'd66192,
                  18'h1FFFF, 18'h20000, 18'h3FFFF};
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      order_shadow = ORDER_4;
      tx_idle_pct = 9;
      rx_idle_pct = 73;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (orders[p]) begin
         write_order(orders[p]);
         tx_idle_pct = (p < 2) ? 9 : (p < 4) ? 73 : 0;
         rx_idle_pct = (p < 2) ? 73 : (p < 4) ? 9 : 0;
         if (p < 3) begin
            foreach (corners[i])
               offset_queue.push_back(corners[i]);
         end
         push_random(160);
         wait_drained();
         push_random(150);
      end
      wait_drained();
      if (mismatches == 0 && weights_queue.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
